>>> hw/rtl/frt_pkg.sv
// Package: types, constants and codes shared by the fragment reassembly tracker.
package frt_pkg;

    localparam int unsigned SLOTS_DEF         = 8;
    localparam int unsigned MAX_FRAGMENTS_DEF = 32;
    localparam logic [15:0] TIMEOUT_RST       = 16'd3000;
    localparam logic [7:0]  FIRST_PAY_RST     = 8'd200;
    localparam logic [7:0]  NEXT_PAY_RST      = 8'd220;

    localparam logic [1:0] ACT_FIRST  = 2'd0;
    localparam logic [1:0] ACT_NEXT   = 2'd1;
    localparam logic [1:0] ACT_SCAN   = 2'd2;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam logic [2:0] ST_STORED    = 3'd0;
    localparam logic [2:0] ST_COMPLETED = 3'd1;
    localparam logic [2:0] ST_DIRECT    = 3'd2;
    localparam logic [2:0] ST_NO_ENTRY  = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;
    localparam logic [2:0] ST_DUPLICATE = 3'd5;
    localparam logic [2:0] ST_RANGE     = 3'd6;
    localparam logic [2:0] ST_SCANNED   = 3'd7;

    localparam logic [1:0] REG_TIMEOUT   = 2'd0;
    localparam logic [1:0] REG_FIRST_PAY = 2'd1;
    localparam logic [1:0] REG_NEXT_PAY  = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [47:0] sender_address;
        logic [15:0] message_id;
        logic [15:0] message_bytes;
        logic [4:0]  fragment_index;
        logic [31:0] now_ticks;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  slot_index;
        logic [15:0] write_offset;
        logic [3:0]  expired_count;
        logic [31:0] next_deadline;
        logic        none_pending;
    } t_out_beat;

    typedef enum logic [3:0] {
        S_IDLE, S_DIV, S_SEARCH, S_FIRST_END, S_NEXT_CHK, S_NEXT_MUL,
        S_NEXT_END, S_SCAN, S_SCAN_END, S_OUT
    } t_state;

    // divider control and status
    typedef struct packed {
        logic        start;
        logic [15:0] dividend;
        logic [7:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic        busy;
        logic [15:0] quotient;
    } t_div_rsp;

endpackage

>>> hw/rtl/frt_divider.sv
// Restoring divider, one quotient bit per cycle, 16 by 8 bits.
module frt_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  frt_pkg::t_div_req i_req,
    output frt_pkg::t_div_rsp o_rsp
);
    import frt_pkg::*;

    logic [4:0]  r_cnt, n_cnt;
    logic [15:0] r_quo, n_quo;
    logic [8:0]  r_rem, n_rem;
    logic [7:0]  r_dvs, n_dvs;
    logic [8:0]  w_trial;
    logic [8:0]  w_diff;

    assign w_trial = {r_rem[7:0], r_quo[15]};
    assign w_diff  = w_trial - {1'b0, r_dvs};

    always_comb begin
        n_cnt = r_cnt;
        n_quo = r_quo;
        n_rem = r_rem;
        n_dvs = r_dvs;
        if (i_req.start) begin
            n_cnt = 5'd16;
            n_quo = i_req.dividend;
            n_rem = '0;
            n_dvs = i_req.divisor;
        end else if (r_cnt != 5'd0) begin
            n_cnt = r_cnt - 5'd1;
            if (!w_diff[8]) begin
                n_rem = w_diff;
                n_quo = {r_quo[14:0], 1'b1};
            end else begin
                n_rem = w_trial;
                n_quo = {r_quo[14:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_rsp.busy     = (r_cnt != 5'd0) || i_req.start;
    assign o_rsp.quotient = r_quo;
endmodule

>>> hw/rtl/fragment_reassembly_tracker.sv
// Top level: slot table, sequencer and configuration port of the tracker.
// First fragment: divide, slot walk, table write; a short message completes directly,
// too many fragments end after the divide. Next fragment: slot walk, range check, offset
// multiply, table write (an unknown message or bad index ends at the check). Scan: slot walk.
// Ready only in idle, after the last result is taken. Reset (synchronous, active low)
// clears slot valid bits and loads the register defaults; slot payload is left unset.
module fragment_reassembly_tracker #(
    parameter int unsigned SLOTS         = frt_pkg::SLOTS_DEF,
    parameter int unsigned MAX_FRAGMENTS = frt_pkg::MAX_FRAGMENTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  frt_pkg::t_in_beat  i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output frt_pkg::t_out_beat o_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import frt_pkg::*;

    localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int unsigned CW = $clog2(SLOTS + 1);

    // configuration registers
    logic [15:0] r_timeout;
    logic [7:0]  r_first_pay, r_next_pay;
    logic        w_wr;
    logic [1:0]  w_reg;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_reg  = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout   <= TIMEOUT_RST;
            r_first_pay <= FIRST_PAY_RST;
            r_next_pay  <= NEXT_PAY_RST;
        end else if (w_wr) begin
            case (w_reg)
                REG_TIMEOUT:   r_timeout   <= pwdata[15:0];
                REG_FIRST_PAY: r_first_pay <= pwdata[7:0];
                REG_NEXT_PAY:  r_next_pay  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg)
            REG_TIMEOUT:   prdata = {16'd0, r_timeout};
            REG_FIRST_PAY: prdata = {24'd0, r_first_pay};
            REG_NEXT_PAY:  prdata = {24'd0, r_next_pay};
            default:       prdata = '0;
        endcase
    end

    // treat a zero payload size as one
    logic [7:0] w_fp, w_np;
    assign w_fp = (r_first_pay == 8'd0) ? 8'd1 : r_first_pay;
    assign w_np = (r_next_pay == 8'd0) ? 8'd1 : r_next_pay;

    // slot table, one entry of flops each, read at the walk pointer
    logic [SLOTS-1:0] r_vld, n_vld;
    logic [47:0] r_snd  [SLOTS];
    logic [15:0] r_msg  [SLOTS];
    logic [5:0]  r_cnt  [SLOTS];
    logic [31:0] r_mask [SLOTS];
    logic [31:0] r_seen [SLOTS];

    t_state      r_state, n_state;
    t_in_beat    r_in, n_in;
    t_out_beat   r_out, n_out;
    logic        r_ovld, n_ovld;
    logic [SW-1:0] r_ptr, n_ptr;
    logic [CW-1:0] r_exp, n_exp;
    logic        r_hit, n_hit;
    logic [SW-1:0] r_hslot, n_hslot;
    logic        r_free, n_free;
    logic [SW-1:0] r_fslot, n_fslot;
    logic [5:0]  r_fcnt, n_fcnt;
    logic        r_any, n_any;
    logic [31:0] r_min, n_min;
    logic [15:0] r_prod, n_prod;
    logic        w_last;

    // table write controls
    logic        w_tw_new, w_tw_upd;
    logic [SW-1:0] w_tw_slot;

    t_div_req w_dreq;
    t_div_rsp w_drsp;

    frt_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_dreq),
        .o_rsp  (w_drsp)
    );

    logic        w_acc;
    logic        w_key_eq;
    logic [31:0] w_dl;
    logic [16:0] w_qcnt;
    logic [31:0] w_newmask, w_full;

    assign o_stall  = (r_state != S_IDLE);
    assign w_acc    = i_valid && !o_stall;
    assign w_last   = (r_ptr == SW'(SLOTS - 1));
    assign w_key_eq = r_vld[r_ptr] && (r_snd[r_ptr] == r_in.sender_address)
                      && (r_msg[r_ptr] == r_in.message_id);
    assign w_dl     = r_seen[r_ptr] + {16'd0, r_timeout};
    assign w_qcnt   = {1'b0, w_drsp.quotient} + 17'd2;
    assign w_newmask = r_mask[r_hslot] | (32'd1 << r_in.fragment_index);
    assign w_full   = 32'((64'd1 << r_cnt[r_hslot]) - 64'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovld  <= 1'b0;
            r_vld   <= '0;
        end else begin
            r_state <= n_state;
            r_ovld  <= n_ovld;
            r_vld   <= n_vld;
        end
        r_in    <= n_in;
        r_out   <= n_out;
        r_ptr   <= n_ptr;
        r_exp   <= n_exp;
        r_hit   <= n_hit;
        r_hslot <= n_hslot;
        r_free  <= n_free;
        r_fslot <= n_fslot;
        r_fcnt  <= n_fcnt;
        r_any   <= n_any;
        r_min   <= n_min;
        r_prod  <= n_prod;
        if (w_tw_new) begin
            r_snd[w_tw_slot]  <= r_in.sender_address;
            r_msg[w_tw_slot]  <= r_in.message_id;
            r_cnt[w_tw_slot]  <= r_fcnt;
            r_mask[w_tw_slot] <= 32'd1;
            r_seen[w_tw_slot] <= r_in.now_ticks;
        end else if (w_tw_upd) begin
            r_mask[w_tw_slot] <= w_newmask;
            r_seen[w_tw_slot] <= r_in.now_ticks;
        end
    end

    always_comb begin
        n_state = r_state;
        n_in    = r_in;
        n_out   = r_out;
        n_ovld  = r_ovld;
        n_vld   = r_vld;
        n_ptr   = r_ptr;
        n_exp   = r_exp;
        n_hit   = r_hit;
        n_hslot = r_hslot;
        n_free  = r_free;
        n_fslot = r_fslot;
        n_fcnt  = r_fcnt;
        n_any   = r_any;
        n_min   = r_min;
        n_prod  = r_prod;
        w_tw_new  = 1'b0;
        w_tw_upd  = 1'b0;
        w_tw_slot = r_hslot;
        w_dreq.start    = 1'b0;
        w_dreq.dividend = 16'(r_in.message_bytes - {8'd0, w_fp} - 16'd1);
        w_dreq.divisor  = w_np;

        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_in    = i_data;
                    n_ptr   = '0;
                    n_hit   = 1'b0;
                    n_free  = 1'b0;
                    n_exp   = '0;
                    n_any   = 1'b0;
                    n_fcnt  = 6'd0;
                    n_out   = '0;
                    case (i_data.action)
                        ACT_FIRST: n_state = S_DIV;
                        ACT_NEXT:  n_state = S_SEARCH;
                        ACT_SCAN:  n_state = S_SCAN;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_DIV: begin
                // short message completes at once
                if (r_in.message_bytes <= {8'd0, w_fp}) begin
                    n_out.status = ST_DIRECT;
                    n_state = S_OUT;
                end else if (!w_drsp.busy && r_fcnt == 6'd63) begin
                    if (w_qcnt > 17'(MAX_FRAGMENTS)) begin
                        n_out.status = ST_RANGE;
                        n_state = S_OUT;
                    end else begin
                        n_fcnt  = 6'(w_qcnt);
                        n_state = S_SEARCH;
                    end
                end else if (r_fcnt != 6'd63) begin
                    w_dreq.start = 1'b1;
                    n_fcnt = 6'd63;
                end
            end
            S_SEARCH: begin
                if (w_key_eq && !r_hit) begin
                    n_hit = 1'b1;
                    n_hslot = r_ptr;
                end
                if (!r_vld[r_ptr] && !r_free) begin
                    n_free = 1'b1;
                    n_fslot = r_ptr;
                end
                if (w_last) begin
                    n_state = (r_in.action == ACT_FIRST) ? S_FIRST_END : S_NEXT_CHK;
                end else begin
                    n_ptr = r_ptr + SW'(1);
                end
            end
            S_FIRST_END: begin
                n_fcnt = 6'd0;
                if (r_hit) begin
                    n_out.status = ST_DUPLICATE;
                    n_out.slot_index = 3'(r_hslot);
                end else if (!r_free) begin
                    n_out.status = ST_FULL;
                end else begin
                    w_tw_new  = 1'b1;
                    w_tw_slot = r_fslot;
                    n_vld[r_fslot] = 1'b1;
                    n_out.status = ST_STORED;
                    n_out.slot_index = 3'(r_fslot);
                end
                n_state = S_OUT;
            end
            S_NEXT_CHK: begin
                if (!r_hit) begin
                    n_out.status = ST_NO_ENTRY;
                    n_state = S_OUT;
                end else if ({1'b0, r_in.fragment_index} >= r_cnt[r_hslot]) begin
                    n_out.status = ST_RANGE;
                    n_out.slot_index = 3'(r_hslot);
                    n_state = S_OUT;
                end else begin
                    n_prod  = {11'd0, 5'(r_in.fragment_index - 5'd1)} * {8'd0, w_np};
                    n_state = S_NEXT_MUL;
                end
            end
            S_NEXT_MUL: begin
                n_out.write_offset = (r_in.fragment_index == 5'd0) ? 16'd0
                                     : r_prod + {8'd0, w_fp};
                n_out.slot_index = 3'(r_hslot);
                n_state = S_NEXT_END;
            end
            S_NEXT_END: begin
                w_tw_upd = 1'b1;
                if ((w_newmask & w_full) == w_full) begin
                    n_vld[r_hslot] = 1'b0;
                    n_out.status = ST_COMPLETED;
                end else begin
                    n_out.status = ST_STORED;
                end
                n_state = S_OUT;
            end
            S_SCAN: begin
                if (r_vld[r_ptr]) begin
                    if (w_dl < r_in.now_ticks) begin
                        n_vld[r_ptr] = 1'b0;
                        n_exp = r_exp + CW'(1);
                    end else if (!r_any || r_seen[r_ptr] < r_min) begin
                        n_min = r_seen[r_ptr];
                        n_any = 1'b1;
                    end
                end
                if (w_last) begin
                    n_state = S_SCAN_END;
                end else begin
                    n_ptr = r_ptr + SW'(1);
                end
            end
            S_SCAN_END: begin
                n_out.status = ST_SCANNED;
                n_out.expired_count = (r_exp > CW'(15)) ? 4'd15 : 4'(r_exp);
                n_out.next_deadline = r_any ? r_min + {16'd0, r_timeout} : 32'hFFFF_FFFF;
                n_out.none_pending = !r_any;
                n_state = S_OUT;
            end
            S_OUT: begin
                // hold the result register until the sink takes the beat
                if (!r_ovld) begin
                    n_ovld = 1'b1;
                end else if (!i_stall) begin
                    n_ovld = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_valid = r_ovld;
    assign o_data  = r_out;

`ifndef ASSERT_OFF
    a_busy_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("result shown while idle");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_data)))
        else $error("stalled result changed");
    a_scan_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.status == ST_SCANNED && o_data.none_pending)
        |-> o_data.next_deadline == 32'hFFFF_FFFF) else $error("deadline mismatch");
`endif
endmodule

>>> sim/testbench.sv
// Testbench for the fragment reassembly tracker: scoreboard, stimulus and checks.
`timescale 1ns / 1ps

module testbench;
    import frt_pkg::*;

    // Scoreboard: holds its own copy of the slot table and the registers, predicts one
    // result per accepted beat except an unused action, and checks results in order.
    class reassembly_scoreboard;
        bit          valid_q [8];
        bit [47:0]   sender_q [8];
        bit [15:0]   msg_q [8];
        int unsigned count_q [8];
        bit [31:0]   mask_q [8];
        bit [31:0]   seen_q [8];
        bit [15:0]   timeout;
        bit [7:0]    first_pay;
        bit [7:0]    next_pay;
        t_out_beat   pending_results [$];
        int          errors;
        int          checked;
        int          n_status [8];

        function void clear_table();
            foreach (valid_q[i]) valid_q[i] = 0;
            timeout   = TIMEOUT_RST;
            first_pay = FIRST_PAY_RST;
            next_pay  = NEXT_PAY_RST;
        endfunction

        function void set_register(logic [1:0] idx, logic [31:0] val);
            case (idx)
                REG_TIMEOUT:   timeout   = val[15:0];
                REG_FIRST_PAY: first_pay = val[7:0];
                REG_NEXT_PAY:  next_pay  = val[7:0];
                default: ;
            endcase
        endfunction

        function int find_slot(bit [47:0] snd, bit [15:0] msg);
            for (int i = 0; i < 8; i++)
                if (valid_q[i] && sender_q[i] == snd && msg_q[i] == msg) return i;
            return -1;
        endfunction

        function int occupied();
            int n;
            n = 0;
            foreach (valid_q[i]) n += valid_q[i];
            return n;
        endfunction

        // Note an accepted input beat and queue what it should produce.
        function void note_beat(t_in_beat b);
            t_out_beat   r;
            int unsigned fp, np, cnt, idx, off;
            int          s;
            bit [31:0]   full, minseen;
            bit          any;
            int          expired;
            r  = '0;
            fp = (first_pay == 0) ? 1 : first_pay;
            np = (next_pay == 0) ? 1 : next_pay;
            case (b.action)
                ACT_FIRST: begin
                    cnt = 1;
                    if (b.message_bytes > fp) cnt = 2 + (b.message_bytes - fp - 1) / np;
                    s = find_slot(b.sender_address, b.message_id);
                    if (cnt > 32) r.status = ST_RANGE;
                    else if (cnt == 1) r.status = ST_DIRECT;
                    else if (s >= 0) begin
                        r.status = ST_DUPLICATE;
                        r.slot_index = s[2:0];
                    end else if (occupied() == 8) r.status = ST_FULL;
                    else begin
                        for (s = 0; valid_q[s]; s++) ;
                        valid_q[s]  = 1;
                        sender_q[s] = b.sender_address;
                        msg_q[s]    = b.message_id;
                        count_q[s]  = cnt;
                        mask_q[s]   = 1;
                        seen_q[s]   = b.now_ticks;
                        r.status     = ST_STORED;
                        r.slot_index = s[2:0];
                    end
                end
                ACT_NEXT: begin
                    s = find_slot(b.sender_address, b.message_id);
                    idx = b.fragment_index;
                    if (s < 0) r.status = ST_NO_ENTRY;
                    else if (idx >= count_q[s]) begin
                        r.status = ST_RANGE;
                        r.slot_index = s[2:0];
                    end else begin
                        off = (idx == 0) ? 0 : fp + (idx - 1) * np;
                        mask_q[s] |= 32'd1 << idx;
                        seen_q[s] = b.now_ticks;
                        full = 32'((64'd1 << count_q[s]) - 1);
                        r.slot_index   = s[2:0];
                        r.write_offset = off[15:0];
                        if ((mask_q[s] & full) == full) begin
                            valid_q[s] = 0;
                            r.status = ST_COMPLETED;
                        end else r.status = ST_STORED;
                    end
                end
                ACT_SCAN: begin
                    expired = 0;
                    any = 0;
                    minseen = 0;
                    for (int i = 0; i < 8; i++) begin
                        if (!valid_q[i]) continue;
                        if (32'(seen_q[i] + timeout) < b.now_ticks) begin
                            valid_q[i] = 0;
                            expired++;
                        end else if (!any || seen_q[i] < minseen) begin
                            minseen = seen_q[i];
                            any = 1;
                        end
                    end
                    r.status = ST_SCANNED;
                    r.expired_count = expired[3:0];
                    r.next_deadline = any ? 32'(minseen + timeout) : 32'hFFFF_FFFF;
                    r.none_pending  = !any;
                end
                default: return;   // unused action: no result
            endcase
            pending_results.push_back(r);
        endfunction

        // Compare one accepted result beat with the oldest prediction.
        function void check_result(t_out_beat got);
            t_out_beat e;
            if (pending_results.size() == 0) begin
                $error("unexpected result beat %h", got);
                errors++;
                return;
            end
            e = pending_results.pop_front();
            checked++;
            n_status[e.status]++;
            if (got.status !== e.status) begin
                $error("status exp %0d got %0d", e.status, got.status); errors++;
            end
            if (got.slot_index !== e.slot_index) begin
                $error("slot_index exp %0d got %0d", e.slot_index, got.slot_index); errors++;
            end
            if (got.write_offset !== e.write_offset) begin
                $error("write_offset exp %0d got %0d", e.write_offset, got.write_offset);
                errors++;
            end
            if (got.expired_count !== e.expired_count) begin
                $error("expired_count exp %0d got %0d", e.expired_count, got.expired_count);
                errors++;
            end
            if (got.next_deadline !== e.next_deadline) begin
                $error("next_deadline exp %h got %h", e.next_deadline, got.next_deadline);
                errors++;
            end
            if (got.none_pending !== e.none_pending) begin
                $error("none_pending exp %0d got %0d", e.none_pending, got.none_pending);
                errors++;
            end
        endfunction
    endclass

    logic       i_clk, i_rst_n;
    logic       i_valid, o_stall, o_valid, i_stall;
    t_in_beat   i_data;
    t_out_beat  o_data;
    logic       psel, penable, pwrite, pready;
    logic [3:0] paddr;
    logic [31:0] pwdata, prdata;

    fragment_reassembly_tracker u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_data(i_data),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    reassembly_scoreboard sb;

    int send_idle_pct;      // percent of cycles the sender holds off
    int recv_idle_pct;      // percent of cycles the receiver stalls
    bit recv_hold;          // long receiver hold-off for back-pressure
    int quiet_cycles;
    int beats_sent;
    bit [31:0] tick;

    // Key pool: a few senders and ids so duplicates and matches are common.
    bit [47:0] key_snd [6];
    bit [15:0] key_msg [6];

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    // Receiver: random stall, plus a long hold when asked.
    always @(negedge i_clk) begin
        if (!i_rst_n) i_stall <= 1'b0;
        else i_stall <= recv_hold || ($urandom_range(99) < recv_idle_pct);
    end

    // Check every result beat taken at a rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_result(o_data);
    end

    // Watchdog: count cycles without any beat accepted on either side.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || psel) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Offer one beat and hold it until the block takes it.
    task automatic send_beat(t_in_beat b, bit idle_ok);
        while (idle_ok && $urandom_range(99) < send_idle_pct) @(negedge i_clk);
        i_data  <= b;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        sb.note_beat(b);
        beats_sent++;
        @(negedge i_clk);
        i_valid <= 1'b0;
        i_data  <= '0;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        while (sb.pending_results.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);   // covers a result-free unused action
    endtask

    // APB write: setup then access; pready is always high.
    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        sb.set_register(idx, val);
        @(negedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        @(negedge i_clk);
    endtask

    function automatic t_in_beat make_beat(logic [1:0] act, int k, bit [15:0] bytes,
                                           bit [4:0] idx);
        t_in_beat b;
        b.action = act;
        b.sender_address = key_snd[k];
        b.message_id = key_msg[k];
        b.message_bytes = bytes;
        b.fragment_index = idx;
        b.now_ticks = tick;
        return b;
    endfunction

    // Random beat: mostly well-formed messages drawn from the key pool.
    task automatic random_beat();
        t_in_beat b;
        int r, k;
        k = $urandom_range(5);
        tick += $urandom_range(300);
        r = $urandom_range(99);
        if (r < 30) b = make_beat(ACT_FIRST, k, 16'($urandom_range(1200)), 5'd0);
        else if (r < 80) b = make_beat(ACT_NEXT, k, 16'($urandom), 5'($urandom_range(7)));
        else if (r < 90) b = make_beat(ACT_SCAN, k, 16'($urandom), 5'($urandom));
        else begin
            b = t_in_beat'(119'({$urandom, $urandom, $urandom, $urandom}));
            if (b.action == ACT_UNUSED && $urandom_range(1)) b.action = ACT_NEXT;
            if ($urandom_range(1)) b.now_ticks = tick;
        end
        send_beat(b, 1'b1);
    endtask

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++) random_beat();
    endtask

    initial begin
        int hold_len;
        sb = new();
        sb.clear_table();
        i_rst_n = 0; i_valid = 0; i_data = '0; i_stall = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        recv_hold = 0; send_idle_pct = 0; recv_idle_pct = 0;
        quiet_cycles = 0; beats_sent = 0; tick = 32'd1000;
        for (int i = 0; i < 6; i++) begin
            key_snd[i] = 48'({$urandom, $urandom});
            key_msg[i] = 16'($urandom);
        end
        key_snd[0] = '1; key_msg[0] = '1;    // all-ones key
        key_snd[1] = '0; key_msg[1] = '0;    // all-zeros key
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // Directed: defaults, direct complete, extremes, range, duplicate, full.
        send_beat(make_beat(ACT_SCAN, 0, 0, 0), 0);                 // empty scan
        send_beat(make_beat(ACT_FIRST, 0, 0, 0), 0);                // zero length
        send_beat(make_beat(ACT_FIRST, 0, 200, 0), 0);              // exactly one fragment
        send_beat(make_beat(ACT_FIRST, 0, 16'hFFFF, 0), 0);         // too many fragments
        send_beat(make_beat(ACT_FIRST, 0, 201, 0), 0);              // two fragments
        send_beat(make_beat(ACT_FIRST, 0, 500, 0), 0);              // duplicate key
        send_beat(make_beat(ACT_NEXT, 0, 0, 31), 0);                // index out of range
        send_beat(make_beat(ACT_NEXT, 1, 0, 1), 0);                 // unknown message
        send_beat(make_beat(ACT_NEXT, 0, 0, 0), 0);                 // index zero again
        send_beat(make_beat(ACT_NEXT, 0, 0, 1), 0);                 // completes
        for (int k = 0; k < 6; k++) send_beat(make_beat(ACT_FIRST, k, 1000, 0), 0);
        key_msg[5]++; send_beat(make_beat(ACT_FIRST, 5, 1000, 0), 0);
        key_msg[5]++; send_beat(make_beat(ACT_FIRST, 5, 1000, 0), 0);
        key_msg[5]++; send_beat(make_beat(ACT_FIRST, 5, 1000, 0), 0); // table full
        send_beat(make_beat(ACT_NEXT, 2, 0, 5), 0);
        send_beat(t_in_beat'({ACT_UNUSED, 117'h0}), 0);             // unused action
        tick = 32'hFFFF_FFFF;
        send_beat(make_beat(ACT_SCAN, 0, 0, 0), 0);                 // expire all
        tick = 32'd5000;
        wait_drained();

        // Register extremes: zero payloads act as one, max timeout wraps.
        write_reg(REG_TIMEOUT, 32'd65535);
        write_reg(REG_FIRST_PAY, 32'd0);
        write_reg(REG_NEXT_PAY, 32'd0);
        tick = 32'hFFFF_FF00;
        send_beat(make_beat(ACT_FIRST, 3, 33, 0), 0);
        send_beat(make_beat(ACT_FIRST, 4, 2, 0), 0);
        send_beat(make_beat(ACT_NEXT, 4, 0, 1), 0);
        send_beat(make_beat(ACT_SCAN, 0, 0, 0), 0);
        wait_drained();
        write_reg(REG_TIMEOUT, 32'd1);
        write_reg(REG_FIRST_PAY, 32'd255);
        write_reg(REG_NEXT_PAY, 32'd255);
        tick = 32'd100;

        // Phase 1: sender idles 29%, receiver 69%.
        send_idle_pct = 29; recv_idle_pct = 69;
        random_phase(60);
        wait_drained();
        write_reg(REG_TIMEOUT, 32'd400);
        write_reg(REG_FIRST_PAY, 32'd1);
        write_reg(REG_NEXT_PAY, 32'd37);
        random_phase(120);

        // Long receiver hold-off while the sender keeps offering beats.
        fork
            begin
                recv_hold = 1;
                hold_len = 400;
                repeat (hold_len) @(negedge i_clk);
                recv_hold = 0;
            end
            random_phase(10);
        join
        wait_drained();   // sender pauses until every result is back

        // Phase 2: roles swapped.
        write_reg(REG_TIMEOUT, 32'd1500);
        write_reg(REG_FIRST_PAY, 32'd200);
        write_reg(REG_NEXT_PAY, 32'd60);
        send_idle_pct = 69; recv_idle_pct = 29;
        random_phase(170);
        wait_drained();

        // Phase 3: no idling.
        write_reg(REG_TIMEOUT, 32'd3000);
        write_reg(REG_FIRST_PAY, 32'd128);
        write_reg(REG_NEXT_PAY, 32'd200);
        send_idle_pct = 0; recv_idle_pct = 0;
        random_phase(170);
        wait_drained();

        $display("Covered %0d beats, %0d results checked across six register settings.",
                 beats_sent, sb.checked);
        $display("Results by status: stored %0d done %0d direct %0d noent %0d full %0d dup %0d",
                 sb.n_status[0], sb.n_status[1], sb.n_status[2], sb.n_status[3],
                 sb.n_status[4], sb.n_status[5]);
        if (sb.errors == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end
endmodule
